>>> rtl/core/nrp_pkg.sv
// ----------------------------------------------------------------------------
// nrp_pkg
// Shared types, constants and character helpers for the RMC sentence parser.
// ----------------------------------------------------------------------------
package nrp_pkg;

    localparam int LINE_MAX_BYTES = 128;
    localparam int MAX_FIELDS     = 17;
    localparam int POS_W          = $clog2(LINE_MAX_BYTES + 1);
    localparam int FLD_W          = $clog2(MAX_FIELDS + 1);
    localparam int QUEUE_DEPTH    = 2;
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_A      = 8'h41;
    localparam logic [7:0] CHAR_R      = 8'h52;
    localparam logic [7:0] CHAR_M      = 8'h4D;
    localparam logic [7:0] CHAR_C      = 8'h43;

    localparam logic [11:0] YEAR_BASE   = 12'd2000;
    localparam logic [6:0]  SYNC_SECOND = 7'd30;
    localparam logic [6:0]  SECOND_NONE = 7'd99;
    localparam logic [3:0]  CHAR_LIMIT  = 4'd15;

    localparam logic [FLD_W-1:0] FIELD_TIME   = FLD_W'(1);
    localparam logic [FLD_W-1:0] FIELD_STATUS = FLD_W'(2);
    localparam logic [FLD_W-1:0] FIELD_LAT    = FLD_W'(3);
    localparam logic [FLD_W-1:0] FIELD_LON    = FLD_W'(5);
    localparam logic [FLD_W-1:0] FIELD_DATE   = FLD_W'(9);

    typedef enum logic [1:0] {
        KIND_CHAR,
        KIND_START,
        KIND_END
    } kind_t;

    typedef enum logic [1:0] {
        CS_BEFORE,
        CS_HI,
        CS_LO,
        CS_DONE
    } cs_phase_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       sync;
    } qent_t;

    function automatic logic [3:0] digit_of(input logic [7:0] c);
        if (c inside {[8'h30:8'h39]})
            return c[3:0];
        return 4'd0;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10)
            return 8'h30 + {4'd0, nib};
        return 8'h41 + {4'd0, nib} - 8'd10;
    endfunction

    function automatic logic [6:0] lat_deg_weight(input logic [3:0] ci);
        case (ci)
            4'd0:    return 7'd10;
            4'd1:    return 7'd1;
            default: return 7'd0;
        endcase
    endfunction

    function automatic logic [9:0] lon_deg_weight(input logic [3:0] ci);
        case (ci)
            4'd0:    return 10'd100;
            4'd1:    return 10'd10;
            4'd2:    return 10'd1;
            default: return 10'd0;
        endcase
    endfunction

    function automatic logic [19:0] lat_min_weight(input logic [3:0] ci);
        case (ci)
            4'd2:    return 20'd100000;
            4'd3:    return 20'd10000;
            4'd5:    return 20'd1000;
            4'd6:    return 20'd100;
            4'd7:    return 20'd10;
            4'd8:    return 20'd1;
            default: return 20'd0;
        endcase
    endfunction

    function automatic logic [19:0] lon_min_weight(input logic [3:0] ci);
        case (ci)
            4'd3:    return 20'd100000;
            4'd4:    return 20'd10000;
            4'd6:    return 20'd1000;
            4'd7:    return 20'd100;
            4'd8:    return 20'd10;
            4'd9:    return 20'd1;
            default: return 20'd0;
        endcase
    endfunction

    function automatic logic [6:0] pair_value(input logic [3:0] hi, input logic [3:0] lo);
        return 7'({3'd0, hi}) * 7'd10 + 7'({3'd0, lo});
    endfunction

endpackage

>>> rtl/core/nmea_rmc_sentence_parser_core.sv
// ----------------------------------------------------------------------------
// nmea_rmc_sentence_parser_core
// RMC sentence parser: byte front end, short queue, parsing back end.
// ----------------------------------------------------------------------------
// The block takes received bytes while in_stall is low and produces at most
// one result per line, on the LF byte, from a registered output stage. A
// free output register takes the result as the LF leaves the queue; a
// result still waiting on out_stall holds the next LF in the back end until
// it is taken. Throughput is one byte per cycle while in_stall is low, set
// by the per-byte update of the parser state in the back end. A two-entry
// queue absorbs up to two bytes while the back end waits on a stalled
// result; after that, in_stall rises. The user must write the checksum
// option through the configuration channel only while the block is idle;
// the block does not enforce this. No clearing pass is needed after reset.
module nmea_rmc_sentence_parser_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    input  logic        sync_request,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  flags,
    output logic [6:0]  hour,
    output logic [6:0]  minute,
    output logic [6:0]  second,
    output logic [6:0]  day,
    output logic [6:0]  month,
    output logic [11:0] year,
    output logic [6:0]  lat_degrees,
    output logic [19:0] lat_minutes_e4,
    output logic [9:0]  lon_degrees,
    output logic [19:0] lon_minutes_e4
);

    logic           req_cs_reg;
    logic           q_valid;
    logic           q_pop;
    nrp_pkg::qent_t q_entry;

    assign cfg_ready = 1'b1;

    // Hold the checksum option
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_cs_reg <= 1'b0;
        else if (cfg_valid && cfg_ready)
            req_cs_reg <= cfg_data;
    end

    nrp_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .sync_request (sync_request),
        .q_valid      (q_valid),
        .q_entry      (q_entry),
        .q_pop        (q_pop)
    );

    nrp_back u_back
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .require_checksum (req_cs_reg),
        .q_valid          (q_valid),
        .q_entry          (q_entry),
        .q_pop            (q_pop),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .flags            (flags),
        .hour             (hour),
        .minute           (minute),
        .second           (second),
        .day              (day),
        .month            (month),
        .year             (year),
        .lat_degrees      (lat_degrees),
        .lat_minutes_e4   (lat_minutes_e4),
        .lon_degrees      (lon_degrees),
        .lon_minutes_e4   (lon_minutes_e4)
    );

endmodule

>>> rtl/core/nrp_front.sv
// ----------------------------------------------------------------------------
// nrp_front
// Accepts received bytes, drops CR and NUL, tags line starts and line ends,
// and holds them in a short queue for the parser back end.
// ----------------------------------------------------------------------------
module nrp_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [7:0]    rx_byte,
    input  logic          sync_request,
    output logic          q_valid,
    output nrp_pkg::qent_t q_entry,
    input  logic          q_pop
);

    nrp_pkg::qent_t                  slot_reg [nrp_pkg::QUEUE_DEPTH];
    logic [nrp_pkg::QPTR_W-1:0]      wr_reg;
    logic [nrp_pkg::QPTR_W-1:0]      rd_reg;
    logic [nrp_pkg::QCNT_W-1:0]      cnt_reg;
    logic                            keep;
    logic                            push;
    nrp_pkg::qent_t                  ent;

    // Classify the incoming byte
    always_comb
    begin
        keep     = (rx_byte != nrp_pkg::CHAR_CR) && (rx_byte != nrp_pkg::CHAR_NUL);
        ent.data = rx_byte;
        ent.sync = sync_request;
        if (rx_byte == nrp_pkg::CHAR_LF)
            ent.kind = nrp_pkg::KIND_END;
        else if (rx_byte == nrp_pkg::CHAR_DOLLAR)
            ent.kind = nrp_pkg::KIND_START;
        else
            ent.kind = nrp_pkg::KIND_CHAR;
    end

    assign in_stall = (cnt_reg == nrp_pkg::QCNT_W'(nrp_pkg::QUEUE_DEPTH));
    assign push     = in_valid && !in_stall && keep;
    assign q_valid  = (cnt_reg != '0);
    assign q_entry  = slot_reg[rd_reg];

    // Store pushed entries
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= ent;
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (q_pop && q_valid)
                rd_reg <= rd_reg + 1'b1;
            if (push && !(q_pop && q_valid))
                cnt_reg <= cnt_reg + 1'b1;
            else if (!push && q_pop && q_valid)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

>>> rtl/core/nrp_back.sv
// ----------------------------------------------------------------------------
// nrp_back
// Parses queued bytes into RMC fields and registers at most one result per sentence.
// ----------------------------------------------------------------------------
module nrp_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           require_checksum,
    input  logic           q_valid,
    input  nrp_pkg::qent_t q_entry,
    output logic           q_pop,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [4:0]     flags,
    output logic [6:0]     hour,
    output logic [6:0]     minute,
    output logic [6:0]     second,
    output logic [6:0]     day,
    output logic [6:0]     month,
    output logic [11:0]    year,
    output logic [6:0]     lat_degrees,
    output logic [19:0]    lat_minutes_e4,
    output logic [9:0]     lon_degrees,
    output logic [19:0]    lon_minutes_e4
);

    logic [nrp_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [3:0]                hdr_reg, hdr_next;
    logic [nrp_pkg::FLD_W-1:0] fld_reg, fld_next;
    logic [3:0]                ci_reg, ci_next;
    logic [7:0]                xor_reg, xor_next;
    nrp_pkg::cs_phase_t        phase_reg, phase_next;
    logic                      csm_reg, csm_next;
    logic                      active_reg, active_next;
    logic [23:0]               tdig_reg, tdig_next;
    logic [23:0]               ddig_reg, ddig_next;
    logic [3:0]                tlen_reg, tlen_next;
    logic [3:0]                dlen_reg, dlen_next;
    logic [6:0]                latd_reg, latd_next;
    logic [19:0]               latm_reg, latm_next;
    logic [9:0]                lond_reg, lond_next;
    logic [19:0]               lonm_reg, lonm_next;
    logic [6:0]                prev_reg, prev_next;

    logic                      out_valid_reg;
    logic [4:0]                flags_reg;
    logic [6:0]                hour_reg, minute_reg, second_reg, day_reg, month_reg;
    logic [11:0]               year_reg;
    logic [6:0]                latd_out_reg;
    logic [19:0]               latm_out_reg;
    logic [9:0]                lond_out_reg;
    logic [19:0]               lonm_out_reg;

    logic                      is_end;
    logic                      cs_ok;
    logic                      taken;
    logic                      line_ok;
    logic                      emit;
    logic [6:0]                hr, mi, se, dd, mo;
    logic [11:0]               yr;
    logic [4:0]                fl;
    logic [7:0]                c;
    logic [3:0]                dg;

    assign c      = q_entry.data;
    assign dg     = nrp_pkg::digit_of(c);
    assign is_end = (q_entry.kind == nrp_pkg::KIND_END);
    assign q_pop  = q_valid && (!is_end || !out_valid_reg || !out_stall);

    // Evaluate the finished sentence
    always_comb
    begin
        cs_ok   = (phase_reg == nrp_pkg::CS_DONE) && csm_reg;
        taken   = active_reg || (tlen_reg == 4'd9 && dlen_reg == 4'd6);
        line_ok = (hdr_reg == 4'hF) && !(require_checksum && !cs_ok);
        hr = '0; mi = '0; se = '0; dd = '0; mo = '0; yr = '0;
        fl = {cs_ok, 1'b0, 1'b1, taken, active_reg};
        if (taken)
        begin
            hr = nrp_pkg::pair_value(tdig_reg[3:0],   tdig_reg[7:4]);
            mi = nrp_pkg::pair_value(tdig_reg[11:8],  tdig_reg[15:12]);
            se = nrp_pkg::pair_value(tdig_reg[19:16], tdig_reg[23:20]);
            dd = nrp_pkg::pair_value(ddig_reg[3:0],   ddig_reg[7:4]);
            mo = nrp_pkg::pair_value(ddig_reg[11:8],  ddig_reg[15:12]);
            yr = 12'(nrp_pkg::pair_value(ddig_reg[19:16], ddig_reg[23:20]))
                 + nrp_pkg::YEAR_BASE;
            if (se == prev_reg)
                fl[2] = 1'b0;
            if (q_entry.sync || (!mi[0] && se == nrp_pkg::SYNC_SECOND))
                fl[3] = 1'b1;
        end
    end

    // Update line state for the popped transaction
    always_comb
    begin
        pos_next = pos_reg;   hdr_next = hdr_reg;     fld_next = fld_reg;
        ci_next = ci_reg;     xor_next = xor_reg;     phase_next = phase_reg;
        csm_next = csm_reg;   active_next = active_reg;
        tdig_next = tdig_reg; ddig_next = ddig_reg;   tlen_next = tlen_reg;
        dlen_next = dlen_reg; latd_next = latd_reg;   latm_next = latm_reg;
        lond_next = lond_reg; lonm_next = lonm_reg;   prev_next = prev_reg;
        emit = 1'b0;
        if (q_pop)
        begin
            if (is_end || q_entry.kind == nrp_pkg::KIND_START)
            begin
                pos_next = '0;   hdr_next = '0;   fld_next = '0;   ci_next = '0;
                xor_next = '0;   phase_next = nrp_pkg::CS_BEFORE;  csm_next = 1'b0;
                active_next = 1'b0; tdig_next = '0; ddig_next = '0;
                tlen_next = '0;  dlen_next = '0;  latd_next = '0;  latm_next = '0;
                lond_next = '0;  lonm_next = '0;
            end
            if (is_end)
            begin
                emit = line_ok;
                if (line_ok && taken)
                    prev_next = se;
            end
            else if (pos_next < nrp_pkg::POS_W'(nrp_pkg::LINE_MAX_BYTES))
            begin
                // Match the sentence header
                if (pos_next == nrp_pkg::POS_W'(0) && c == nrp_pkg::CHAR_DOLLAR)
                    hdr_next[0] = 1'b1;
                if (pos_next == nrp_pkg::POS_W'(3) && c == nrp_pkg::CHAR_R)
                    hdr_next[1] = 1'b1;
                if (pos_next == nrp_pkg::POS_W'(4) && c == nrp_pkg::CHAR_M)
                    hdr_next[2] = 1'b1;
                if (pos_next == nrp_pkg::POS_W'(5) && c == nrp_pkg::CHAR_C)
                    hdr_next[3] = 1'b1;

                // Run the checksum
                if (pos_next != '0)
                begin
                    case (phase_next)
                        nrp_pkg::CS_BEFORE:
                        begin
                            if (pos_next >= nrp_pkg::POS_W'(2) && c == nrp_pkg::CHAR_STAR)
                                phase_next = nrp_pkg::CS_HI;
                            else
                                xor_next = xor_next ^ c;
                        end
                        nrp_pkg::CS_HI:
                        begin
                            csm_next   = (c == nrp_pkg::hex_char(xor_next[7:4]));
                            phase_next = nrp_pkg::CS_LO;
                        end
                        nrp_pkg::CS_LO:
                        begin
                            csm_next   = csm_next && (c == nrp_pkg::hex_char(xor_next[3:0]));
                            phase_next = nrp_pkg::CS_DONE;
                        end
                        default: ;
                    endcase
                end

                // Split fields and take characters
                if (c == nrp_pkg::CHAR_COMMA || c == nrp_pkg::CHAR_STAR)
                begin
                    if (fld_next < nrp_pkg::FLD_W'(nrp_pkg::MAX_FIELDS))
                        fld_next = fld_next + 1'b1;
                    ci_next = '0;
                end
                else if (fld_next < nrp_pkg::FLD_W'(nrp_pkg::MAX_FIELDS)
                         && ci_next < nrp_pkg::CHAR_LIMIT)
                begin
                    case (fld_next)
                        nrp_pkg::FIELD_TIME:
                        begin
                            if (ci_next < 4'd6)
                                tdig_next[ci_next[2:0]*4 +: 4] = dg;
                            tlen_next = ci_next + 1'b1;
                        end
                        nrp_pkg::FIELD_STATUS:
                        begin
                            if (ci_next == 4'd0)
                                active_next = (c == nrp_pkg::CHAR_A);
                        end
                        nrp_pkg::FIELD_LAT:
                        begin
                            latd_next = latd_next
                                        + 7'({3'd0, dg}) * nrp_pkg::lat_deg_weight(ci_next);
                            latm_next = latm_next
                                        + 20'({16'd0, dg}) * nrp_pkg::lat_min_weight(ci_next);
                        end
                        nrp_pkg::FIELD_LON:
                        begin
                            lond_next = lond_next
                                        + 10'({6'd0, dg}) * nrp_pkg::lon_deg_weight(ci_next);
                            lonm_next = lonm_next
                                        + 20'({16'd0, dg}) * nrp_pkg::lon_min_weight(ci_next);
                        end
                        nrp_pkg::FIELD_DATE:
                        begin
                            if (ci_next < 4'd6)
                                ddig_next[ci_next[2:0]*4 +: 4] = dg;
                            dlen_next = ci_next + 1'b1;
                        end
                        default: ;
                    endcase
                    ci_next = ci_next + 1'b1;
                end
                pos_next = pos_next + 1'b1;
            end
        end
    end

    // Hold line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;   hdr_reg <= '0;   fld_reg <= '0;   ci_reg <= '0;
            xor_reg <= '0;   phase_reg <= nrp_pkg::CS_BEFORE;  csm_reg <= 1'b0;
            active_reg <= 1'b0; tdig_reg <= '0; ddig_reg <= '0;
            tlen_reg <= '0;  dlen_reg <= '0;  latd_reg <= '0;  latm_reg <= '0;
            lond_reg <= '0;  lonm_reg <= '0;  prev_reg <= nrp_pkg::SECOND_NONE;
        end
        else
        begin
            pos_reg <= pos_next;   hdr_reg <= hdr_next;     fld_reg <= fld_next;
            ci_reg <= ci_next;     xor_reg <= xor_next;     phase_reg <= phase_next;
            csm_reg <= csm_next;   active_reg <= active_next;
            tdig_reg <= tdig_next; ddig_reg <= ddig_next;   tlen_reg <= tlen_next;
            dlen_reg <= dlen_next; latd_reg <= latd_next;   latm_reg <= latm_next;
            lond_reg <= lond_next; lonm_reg <= lonm_next;   prev_reg <= prev_next;
        end
    end

    // Track result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // Load result payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            flags_reg    <= fl;
            hour_reg     <= hr;
            minute_reg   <= mi;
            second_reg   <= se;
            day_reg      <= dd;
            month_reg    <= mo;
            year_reg     <= yr;
            latd_out_reg <= active_reg ? latd_reg : '0;
            latm_out_reg <= active_reg ? latm_reg : '0;
            lond_out_reg <= active_reg ? lond_reg : '0;
            lonm_out_reg <= active_reg ? lonm_reg : '0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign flags          = flags_reg;
    assign hour           = hour_reg;
    assign minute         = minute_reg;
    assign second         = second_reg;
    assign day            = day_reg;
    assign month          = month_reg;
    assign year           = year_reg;
    assign lat_degrees    = latd_out_reg;
    assign lat_minutes_e4 = latm_out_reg;
    assign lon_degrees    = lond_out_reg;
    assign lon_minutes_e4 = lonm_out_reg;

    a_hdr_needs_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (hdr_reg != '0) |-> (pos_reg != '0))
        else $error("header bits set on an empty line");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && is_end) |=> (pos_reg == '0 && fld_reg == '0))
        else $error("line state not cleared after line end");

    a_field_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fld_reg <= nrp_pkg::FLD_W'(nrp_pkg::MAX_FIELDS))
        else $error("field index beyond limit");

endmodule
